/* src/amtd_pkg.sv */
// ----------------------------------------------------------------------------
// Apogee median threshold detector package
// Shared widths, register indexes, control types and reset values.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package amtd_pkg;

  localparam int DataW = 32;
  localparam int GainW = 17;
  localparam int FracW = 16;
  localparam int CfgIdxW = 1;

  // Sizes of the smoothing datapath.
  localparam int DiffW = DataW + 1;
  localparam int ProdW = DiffW + GainW + 1;
  localparam int QuotW = ProdW - FracW;
  localparam int SumW = QuotW + 1;

  localparam int WindowLengthDef = 8;

  localparam logic [GainW-1:0] GainOne = 17'd65536;
  localparam logic [GainW-1:0] GainReset = 17'd32768;
  localparam logic signed [DataW-1:0] ThresholdReset = 32'sd0;

  localparam logic [CfgIdxW-1:0] CfgIdxGain = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgIdxThreshold = 1'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_FIL,
    ST_INS,
    ST_MED
  } state_e;

  // Stage enables from the sequencer to the smoothing unit.
  typedef struct packed {
    logic load;
    logic mul;
    logic fil;
  } smooth_ctl_t;

endpackage

/* src/amtd_smoother.sv */
// ----------------------------------------------------------------------------
// Exponential smoothing unit
// Computes prior + gain * (raw - prior) / 2^16 with truncation toward zero,
// saturated to 32 bits, over three enabled register stages.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module amtd_smoother (
  input  logic                                  clk_i,
  input  amtd_pkg::smooth_ctl_t                 ctl_i,
  input  logic signed [amtd_pkg::DataW-1:0]     raw_velocity_i,
  input  logic signed [amtd_pkg::DataW-1:0]     prior_velocity_i,
  input  logic        [amtd_pkg::GainW-1:0]     gain_i,
  output logic signed [amtd_pkg::DataW-1:0]     filt_o
);

  logic signed [amtd_pkg::DataW-1:0] raw_q;
  logic signed [amtd_pkg::DataW-1:0] prior_q;
  logic signed [amtd_pkg::DiffW-1:0] diff;
  logic signed [amtd_pkg::ProdW-1:0] diff_ext;
  logic signed [amtd_pkg::ProdW-1:0] gain_ext;
  logic signed [amtd_pkg::ProdW-1:0] prod_d;
  logic signed [amtd_pkg::ProdW-1:0] prod_q;
  logic signed [amtd_pkg::ProdW-1:0] prod_biased;
  logic signed [amtd_pkg::QuotW-1:0] quot;
  logic signed [amtd_pkg::SumW-1:0]  sum;
  logic signed [amtd_pkg::DataW-1:0] filt_d;
  logic signed [amtd_pkg::DataW-1:0] filt_q;
  logic                              sum_fits;

  always_comb begin
    diff = {raw_q[amtd_pkg::DataW-1], raw_q} - {prior_q[amtd_pkg::DataW-1], prior_q};
    diff_ext = {{(amtd_pkg::ProdW-amtd_pkg::DiffW){diff[amtd_pkg::DiffW-1]}}, diff};
    gain_ext = {{(amtd_pkg::ProdW-amtd_pkg::GainW){1'b0}}, gain_i};
    prod_d = diff_ext * gain_ext;
  end

  // A negative product is biased by 2^16 - 1 so the shift rounds toward zero.
  always_comb begin
    prod_biased = prod_q;
    if (prod_q[amtd_pkg::ProdW-1]) begin
      prod_biased = prod_q + {{(amtd_pkg::ProdW-amtd_pkg::FracW){1'b0}},
                              {amtd_pkg::FracW{1'b1}}};
    end
    quot = prod_biased[amtd_pkg::ProdW-1:amtd_pkg::FracW];
    sum = {{(amtd_pkg::SumW-amtd_pkg::DataW){prior_q[amtd_pkg::DataW-1]}}, prior_q}
        + {quot[amtd_pkg::QuotW-1], quot};
    sum_fits = (sum[amtd_pkg::SumW-1:amtd_pkg::DataW-1] == '0) ||
               (sum[amtd_pkg::SumW-1:amtd_pkg::DataW-1] == '1);
    if (sum_fits) begin
      filt_d = sum[amtd_pkg::DataW-1:0];
    end else if (sum[amtd_pkg::SumW-1]) begin
      filt_d = {1'b1, {(amtd_pkg::DataW-1){1'b0}}};
    end else begin
      filt_d = {1'b0, {(amtd_pkg::DataW-1){1'b1}}};
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      raw_q <= raw_velocity_i;
      prior_q <= prior_velocity_i;
    end
    if (ctl_i.mul) begin
      prod_q <= prod_d;
    end
    if (ctl_i.fil) begin
      filt_q <= filt_d;
    end
  end

  assign filt_o = filt_q;

endmodule

/* src/amtd_cell.sv */
// ----------------------------------------------------------------------------
// Sorted window cell
// Holds one window value and its age. On each update the oldest value leaves
// the chain and the new value drops into its sorted place.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module amtd_cell #(
  parameter int AgeW = 3,
  parameter int Index = 0,
  parameter bit IsFirst = 1'b0,
  parameter bit IsLast = 1'b0,
  parameter logic [AgeW-1:0] LastAge = '1
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  logic signed [amtd_pkg::DataW-1:0] new_i,
  input  logic                              evict_before_i,
  input  logic signed [amtd_pkg::DataW-1:0] left_val_i,
  input  logic        [AgeW-1:0]            left_age_i,
  input  logic                              left_le_i,
  input  logic signed [amtd_pkg::DataW-1:0] right_val_i,
  input  logic        [AgeW-1:0]            right_age_i,
  input  logic                              right_le_i,
  output logic signed [amtd_pkg::DataW-1:0] val_o,
  output logic        [AgeW-1:0]            age_o,
  output logic                              le_o,
  output logic                              evict_upto_o
);

  logic signed [amtd_pkg::DataW-1:0] val_q, val_d;
  logic        [AgeW-1:0]            age_q, age_d;
  logic                              evict_here;
  logic signed [amtd_pkg::DataW-1:0] c_val, p_val;
  logic        [AgeW-1:0]            c_age, p_age;
  logic                              c_le, p_le;

  // c is this slot of the chain with the evicted entry removed, p is the slot
  // to the left of it; each carries whether it sorts at or below the new value.
  always_comb begin
    evict_here = (age_q == LastAge);
    le_o = !(val_q > new_i);
    evict_upto_o = evict_before_i | evict_here;

    c_val = evict_upto_o ? right_val_i : val_q;
    c_age = evict_upto_o ? right_age_i : age_q;
    c_le = IsLast ? 1'b0 : (evict_upto_o ? right_le_i : le_o);

    p_val = evict_before_i ? val_q : left_val_i;
    p_age = evict_before_i ? age_q : left_age_i;
    p_le = IsFirst ? 1'b0 : (evict_before_i ? le_o : left_le_i);

    if (c_le) begin
      val_d = c_val;
      age_d = c_age + 1'b1;
    end else if (IsFirst || p_le) begin
      val_d = new_i;
      age_d = '0;
    end else begin
      val_d = p_val;
      age_d = p_age + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      val_q <= '0;
      age_q <= AgeW'(Index);
    end else if (en_i) begin
      val_q <= val_d;
      age_q <= age_d;
    end
  end

  assign val_o = val_q;
  assign age_o = age_q;

endmodule

/* src/amtd_window.sv */
// ----------------------------------------------------------------------------
// Sliding median window
// A chain of sorted cells kept in ascending order, with the median taken
// from the middle cells and compared against the threshold.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module amtd_window #(
  parameter int WindowLength = amtd_pkg::WindowLengthDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              insert_i,
  input  logic signed [amtd_pkg::DataW-1:0] new_i,
  input  logic signed [amtd_pkg::DataW-1:0] threshold_i,
  output logic                              below_o
);

  localparam int AgeW = (WindowLength > 1) ? $clog2(WindowLength) : 1;
  localparam logic [AgeW-1:0] LastAge = AgeW'(WindowLength - 1);
  localparam int MidHi = WindowLength / 2;
  localparam int MidLo = (WindowLength % 2 == 0) ? MidHi - 1 : MidHi;

  logic signed [amtd_pkg::DataW-1:0] val_w [WindowLength];
  logic        [AgeW-1:0]            age_w [WindowLength];
  logic                              le_w  [WindowLength];
  logic                              evict_w [WindowLength];

  logic signed [amtd_pkg::DataW:0]   mid_sum;
  logic signed [amtd_pkg::DataW:0]   mid_adj;
  logic signed [amtd_pkg::DataW-1:0] median;

  for (genvar i = 0; i < WindowLength; i++) begin : g_cell
    logic signed [amtd_pkg::DataW-1:0] left_val, right_val;
    logic        [AgeW-1:0]            left_age, right_age;
    logic                              left_le, right_le, evict_before;

    if (i == 0) begin : g_head
      assign left_val = '0;
      assign left_age = '0;
      assign left_le = 1'b0;
      assign evict_before = 1'b0;
    end else begin : g_body
      assign left_val = val_w[i-1];
      assign left_age = age_w[i-1];
      assign left_le = le_w[i-1];
      assign evict_before = evict_w[i-1];
    end

    if (i == WindowLength - 1) begin : g_tail
      assign right_val = '0;
      assign right_age = '0;
      assign right_le = 1'b0;
    end else begin : g_next
      assign right_val = val_w[i+1];
      assign right_age = age_w[i+1];
      assign right_le = le_w[i+1];
    end

    amtd_cell #(
      .AgeW    (AgeW),
      .Index   (i),
      .IsFirst (i == 0),
      .IsLast  (i == WindowLength - 1),
      .LastAge (LastAge)
    ) u_cell (
      .clk_i          (clk_i),
      .rst_ni         (rst_ni),
      .en_i           (insert_i),
      .new_i          (new_i),
      .evict_before_i (evict_before),
      .left_val_i     (left_val),
      .left_age_i     (left_age),
      .left_le_i      (left_le),
      .right_val_i    (right_val),
      .right_age_i    (right_age),
      .right_le_i     (right_le),
      .val_o          (val_w[i]),
      .age_o          (age_w[i]),
      .le_o           (le_w[i]),
      .evict_upto_o   (evict_w[i])
    );
  end

  // For an odd length both middle taps name the same cell, and halving the
  // doubled value gives it back exactly. The sum is biased when negative so
  // the halving truncates toward zero.
  always_comb begin
    mid_sum = {val_w[MidLo][amtd_pkg::DataW-1], val_w[MidLo]}
            + {val_w[MidHi][amtd_pkg::DataW-1], val_w[MidHi]};
    mid_adj = mid_sum + {{amtd_pkg::DataW{1'b0}}, mid_sum[amtd_pkg::DataW]};
    median = mid_adj[amtd_pkg::DataW:1];
    below_o = (median < threshold_i);
  end

endmodule

/* src/apogee_median_threshold_detector_core.sv */
// ----------------------------------------------------------------------------
// Apogee median threshold detector
// Smooths a velocity sample, pushes it into a sorted sliding window and flags
// apogee when the window median falls below the descent threshold.
// ----------------------------------------------------------------------------
// An input transfer passes the smoother load, multiply and filter registers,
// then the window insert and the output register, one item at a time: a new
// item is taken only once the last reaches the output register; a stalled
// result held there holds the sequencer in the median compare step.
// Reset clears the window to zero and loads gain 0.5 and threshold zero;
// no clearing pass is needed.
`timescale 1ns / 1ps

module apogee_median_threshold_detector_core #(
  parameter int WindowLength = amtd_pkg::WindowLengthDef
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic signed [amtd_pkg::DataW-1:0]     raw_velocity_i,
  input  logic signed [amtd_pkg::DataW-1:0]     prior_velocity_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic signed [amtd_pkg::DataW-1:0]     smoothed_velocity_o,
  output logic                                  apogee_flag_o,
  input  logic                                  cfg_we_i,
  input  logic        [amtd_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic        [amtd_pkg::DataW-1:0]     cfg_data_i
);

  amtd_pkg::state_e state_q, state_d;
  amtd_pkg::smooth_ctl_t smooth_ctl;

  logic        [amtd_pkg::GainW-1:0] gain_q;
  logic signed [amtd_pkg::DataW-1:0] threshold_q;
  logic        [amtd_pkg::GainW-1:0] cfg_gain;

  logic signed [amtd_pkg::DataW-1:0] filt;
  logic                              insert;
  logic                              below;
  logic                              out_load;
  logic                              out_valid_q, out_valid_d;
  logic signed [amtd_pkg::DataW-1:0] smoothed_q;
  logic                              flag_q;

  // Gains above 1.0 are held at 1.0.
  assign cfg_gain = (cfg_data_i[amtd_pkg::GainW-1:0] > amtd_pkg::GainOne) ?
                    amtd_pkg::GainOne : cfg_data_i[amtd_pkg::GainW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q <= amtd_pkg::GainReset;
      threshold_q <= amtd_pkg::ThresholdReset;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        amtd_pkg::CfgIdxGain:      gain_q <= cfg_gain;
        amtd_pkg::CfgIdxThreshold: threshold_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d = state_q;
    smooth_ctl = '0;
    insert = 1'b0;
    out_load = 1'b0;
    in_stall_o = 1'b1;
    case (state_q)
      amtd_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          smooth_ctl.load = 1'b1;
          state_d = amtd_pkg::ST_MUL;
        end
      end
      amtd_pkg::ST_MUL: begin
        smooth_ctl.mul = 1'b1;
        state_d = amtd_pkg::ST_FIL;
      end
      amtd_pkg::ST_FIL: begin
        smooth_ctl.fil = 1'b1;
        state_d = amtd_pkg::ST_INS;
      end
      amtd_pkg::ST_INS: begin
        insert = 1'b1;
        state_d = amtd_pkg::ST_MED;
      end
      amtd_pkg::ST_MED: begin
        // Hold here until the output register is free or being emptied.
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d = amtd_pkg::ST_IDLE;
        end
      end
      default: state_d = amtd_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= amtd_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  amtd_smoother u_smoother (
    .clk_i            (clk_i),
    .ctl_i            (smooth_ctl),
    .raw_velocity_i   (raw_velocity_i),
    .prior_velocity_i (prior_velocity_i),
    .gain_i           (gain_q),
    .filt_o           (filt)
  );

  amtd_window #(
    .WindowLength (WindowLength)
  ) u_window (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .insert_i    (insert),
    .new_i       (filt),
    .threshold_i (threshold_q),
    .below_o     (below)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      smoothed_q <= filt;
      flag_q <= below;
    end
  end

  assign out_valid_o = out_valid_q;
  assign smoothed_velocity_o = smoothed_q;
  assign apogee_flag_o = flag_q;

endmodule
